// ===== rtl/cscd_pkg.sv =====
`default_nettype none
package cscd_pkg;

  localparam int CW = 32;            // coordinate width
  localparam int RW = 31;            // radius register width
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_END_A_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_A_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_END_A_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_END_B_X  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_END_B_Y  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_END_B_Z  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_NEGATE   = 3'd7;

  localparam logic [1:0] REG_INSIDE = 2'd0;
  localparam logic [1:0] REG_END    = 2'd1;
  localparam logic [1:0] REG_WALL   = 2'd2;
  localparam logic [1:0] REG_CORNER = 2'd3;

  // datapath widths, all in LSB units
  localparam int D_W    = CW + 1;      // axis component
  localparam int Q_W    = CW + 2;      // 2P - A - B component
  localparam int DD_W   = 2 * CW + 1;  // d^2 term
  localparam int LL_W   = 2 * CW + 2;  // d.d
  localparam int QP_W   = 2 * CW + 3;  // q^2 and q*d terms
  localparam int QQ_W   = 2 * CW + 4;  // q.q
  localparam int QD_W   = 2 * CW + 5;  // q.d, signed
  localparam int DABS_W = 2 * CW + 4;
  localparam int L_W    = CW + 1;      // axis length
  localparam int DIVN_W = 2 * CW + 5;
  localparam int DIVD_W = CW + 2;
  localparam int PARA_W = CW + 3;
  localparam int PSQ_W  = 2 * PARA_W;
  localparam int P4_W   = PSQ_W + 2;
  localparam int O4_W   = QQ_W;
  localparam int S2R_W  = CW + 2;      // root of 4*radial^2
  localparam int H_W    = CW + 1;
  localparam int G_W    = CW + 4;
  localparam int F_W    = CW + 3;
  localparam int FG_W   = CW + 2;
  localparam int SQ_W   = 2 * FG_W;
  localparam int S2_W   = 2 * FG_W + 2;
  localparam int S3R_W  = CW + 3;
  localparam int VAL_W  = CW + 5;
  localparam int NEG_W  = CW + 6;

  typedef logic signed [CW-1:0] coord_t;

endpackage
`default_nettype wire

// ===== rtl/cscd_point_if.sv =====
`default_nettype none
interface cscd_point_if import cscd_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t point_x;
  coord_t point_y;
  coord_t point_z;

  modport source (output valid, output point_x, output point_y, output point_z, input ready);
  modport sink (input valid, input point_x, input point_y, input point_z, output ready);
endinterface
`default_nettype wire

// ===== rtl/cscd_result_if.sv =====
`default_nettype none
interface cscd_result_if import cscd_pkg::*; ();
  logic       valid;
  logic       ready;
  coord_t     distance;
  logic [1:0] region;
  logic       degenerate;
  logic       saturated;

  modport source (output valid, output distance, output region, output degenerate,
                  output saturated, input ready);
  modport sink (input valid, input distance, input region, input degenerate,
                input saturated, output ready);
endinterface
`default_nettype wire

// ===== rtl/cscd_isqrt.sv =====
`default_nettype none
// Digit-by-digit integer square root, one root bit per stage.
// root_o = floor(sqrt(rad_i)), rem_o = rad_i - root_o^2.
module cscd_isqrt #(
  parameter int W  = 33,
  parameter int PW = 1
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           valid_i,
  input  wire logic [2*W-1:0] rad_i,
  input  wire logic [PW-1:0]  pay_i,
  output logic                valid_o,
  output logic [W-1:0]        root_o,
  output logic [W:0]          rem_o,
  output logic [PW-1:0]       pay_o
);

  logic [W:0]     vld;
  logic [2*W-1:0] n_a    [W+1];
  logic [W:0]     rem_a  [W+1];
  logic [W-1:0]   root_a [W+1];
  logic [PW-1:0]  pay_a  [W+1];

  assign vld[0]    = valid_i;
  assign n_a[0]    = rad_i;
  assign rem_a[0]  = '0;
  assign root_a[0] = '0;
  assign pay_a[0]  = pay_i;

  for (genvar k = 0; k < W; k++) begin : g_step
    logic [W+1:0] rem_sh, trial, diff;
    logic         take;

    always_comb begin
      rem_sh = {rem_a[k][W-1:0], n_a[k][2*W-1 -: 2]};
      trial  = {root_a[k], 2'b01};
      diff   = rem_sh - trial;
      take   = rem_sh >= trial;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[k+1] <= 1'b0;
      end else if (en_i) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_a[k+1]    <= {n_a[k][2*W-3:0], 2'b00};
        rem_a[k+1]  <= take ? diff[W:0] : rem_sh[W:0];
        root_a[k+1] <= {root_a[k][W-2:0], take};
        pay_a[k+1]  <= pay_a[k];
      end
    end
  end

  assign valid_o = vld[W];
  assign root_o  = root_a[W];
  assign rem_o   = rem_a[W];
  assign pay_o   = pay_a[W];

endmodule
`default_nettype wire

// ===== rtl/cscd_div.sv =====
`default_nettype none
// Restoring divider, one quotient bit per stage. The upper NW-QW bits of
// the numerator must be below the divisor.
module cscd_div #(
  parameter int QW = 35,
  parameter int DW = 34,
  parameter int NW = 69,
  parameter int PW = 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  input  wire logic [PW-1:0] pay_i,
  output logic               valid_o,
  output logic [QW-1:0]      quo_o,
  output logic [PW-1:0]      pay_o
);

  logic [QW:0]   vld;
  logic [DW-1:0] rem_a [QW+1];
  logic [QW-1:0] lo_a  [QW+1];
  logic [QW-1:0] quo_a [QW+1];
  logic [DW-1:0] den_a [QW+1];
  logic [PW-1:0] pay_a [QW+1];

  assign vld[0]   = valid_i;
  assign rem_a[0] = DW'(num_i[NW-1:QW]);
  assign lo_a[0]  = num_i[QW-1:0];
  assign quo_a[0] = '0;
  assign den_a[0] = den_i;
  assign pay_a[0] = pay_i;

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DW:0] r_sh, diff;
    logic        take;

    always_comb begin
      r_sh = {rem_a[k], lo_a[k][QW-1]};
      diff = r_sh - {1'b0, den_a[k]};
      take = r_sh >= {1'b0, den_a[k]};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[k+1] <= 1'b0;
      end else if (en_i) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_a[k+1] <= take ? diff[DW-1:0] : r_sh[DW-1:0];
        lo_a[k+1]  <= {lo_a[k][QW-2:0], 1'b0};
        quo_a[k+1] <= {quo_a[k][QW-2:0], take};
        den_a[k+1] <= den_a[k];
        pay_a[k+1] <= pay_a[k];
      end
    end
  end

  assign valid_o = vld[QW];
  assign quo_o   = quo_a[QW];
  assign pay_o   = pay_a[QW];

endmodule
`default_nettype wire

// ===== rtl/cscd_front.sv =====
`default_nettype none
// Front end: axis, centered point, dot products. Four stages.
module cscd_front import cscd_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire coord_t        p_i  [3],
  input  wire coord_t        ea_i [3],
  input  wire coord_t        eb_i [3],
  output logic               valid_o,
  output logic               deg_o,
  output logic [LL_W-1:0]    ll_o,
  output logic [QQ_W-1:0]    qq_o,
  output logic [DABS_W-1:0]  dabs_o
);

  logic [3:0] vld_q;

  logic signed [D_W-1:0] d_d [3], d_q [3];
  logic signed [Q_W-1:0] q_d [3], q_q [3];

  logic [DD_W-1:0]        dd_d [3], dd_q [3];
  logic [QP_W-1:0]        qqp_d [3], qqp_q [3];
  logic signed [QP_W-1:0] qd_d [3], qd_q [3];
  logic                   deg2_q, deg3_q, deg4_q;

  logic [LL_W-1:0]        ll_q;
  logic [QQ_W-1:0]        qq3_q, qq4_q;
  logic signed [QD_W-1:0] qds_q;
  logic [LL_W-1:0]        ll4_q;
  logic [DABS_W-1:0]      dabs_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_d[i] = D_W'(eb_i[i]) - D_W'(ea_i[i]);
      q_d[i] = $signed({p_i[i][CW-1], p_i[i], 1'b0}) - Q_W'(ea_i[i]) - Q_W'(eb_i[i]);
    end
  end

  always_comb begin
    logic signed [2*D_W-1:0] pdd;
    logic signed [2*Q_W-1:0] pqq;
    for (int i = 0; i < 3; i++) begin
      pdd      = d_q[i] * d_q[i];
      pqq      = q_q[i] * q_q[i];
      dd_d[i]  = pdd[DD_W-1:0];
      qqp_d[i] = pqq[QP_W-1:0];
      qd_d[i]  = q_q[i] * d_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q    <= d_d;
      q_q    <= q_d;
      dd_q   <= dd_d;
      qqp_q  <= qqp_d;
      qd_q   <= qd_d;
      deg2_q <= (d_q[0] == '0) && (d_q[1] == '0) && (d_q[2] == '0);
      ll_q   <= LL_W'(dd_q[0]) + LL_W'(dd_q[1]) + LL_W'(dd_q[2]);
      qq3_q  <= QQ_W'(qqp_q[0]) + QQ_W'(qqp_q[1]) + QQ_W'(qqp_q[2]);
      qds_q  <= QD_W'(qd_q[0]) + QD_W'(qd_q[1]) + QD_W'(qd_q[2]);
      deg3_q <= deg2_q;
      ll4_q  <= ll_q;
      qq4_q  <= qq3_q;
      dabs_q <= qds_q[QD_W-1] ? DABS_W'(-qds_q) : DABS_W'(qds_q);
      deg4_q <= deg3_q;
    end
  end

  assign valid_o = vld_q[3];
  assign deg_o   = deg4_q;
  assign ll_o    = ll4_q;
  assign qq_o    = qq4_q;
  assign dabs_o  = dabs_q;

endmodule
`default_nettype wire

// ===== rtl/capped_cylinder_signed_distance_core.sv =====
// Signed distance from a point to a capped cylinder, one point per clock.
// The pipeline has four front stages, three digit-by-digit square root
// pipelines (axis length 33, radial 34, corner distance 35 stages), a
// 35-stage restoring divider and ten stages of glue and output. The whole
// pipeline stalls together while the output register holds an item nobody
// has taken. Configuration must be written while no item is in flight; the
// block itself does not enforce this.
`default_nettype none
module capped_cylinder_signed_distance_core import cscd_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CW-1:0]        cfg_data_i,
  cscd_point_if.sink                point_i,
  cscd_result_if.source             result_o
);

  typedef struct packed {
    logic [DABS_W-1:0] dabs;
    logic [QQ_W-1:0]   qq;
    logic              deg;
  } sq1_pay_t;

  typedef struct packed {
    logic [QQ_W-1:0] qq;
    logic [H_W-1:0]  h;
    logic            deg;
  } div_pay_t;

  typedef struct packed {
    logic [G_W-1:0] g;
    logic           deg;
  } sq2_pay_t;

  typedef struct packed {
    logic [1:0]     region;
    logic [G_W-1:0] pre;
    logic           deg;
  } sq3_pay_t;

  localparam logic signed [NEG_W-1:0] V_HI =
    $signed({{(NEG_W-CW+1){1'b0}}, {(CW-1){1'b1}}});
  localparam logic signed [NEG_W-1:0] V_LO =
    $signed({{(NEG_W-CW+1){1'b1}}, {(CW-1){1'b0}}});

  // configuration
  coord_t          ea_q [3], eb_q [3];
  logic [RW-1:0]   rad_q;
  logic            neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ea_q  <= '{default: '0};
      eb_q  <= '{'0, '0, CW'(1) << FRAC_BITS};
      rad_q <= RW'(1) << FRAC_BITS;
      neg_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_END_A_X: ea_q[0] <= cfg_data_i;
        CFG_END_A_Y: ea_q[1] <= cfg_data_i;
        CFG_END_A_Z: ea_q[2] <= cfg_data_i;
        CFG_END_B_X: eb_q[0] <= cfg_data_i;
        CFG_END_B_Y: eb_q[1] <= cfg_data_i;
        CFG_END_B_Z: eb_q[2] <= cfg_data_i;
        CFG_RADIUS:  rad_q   <= cfg_data_i[RW-1:0];
        CFG_NEGATE:  neg_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // global advance: everything moves unless the output item is stuck
  logic out_vld_q;
  logic adv;
  assign adv           = !out_vld_q || result_o.ready;
  assign point_i.ready = adv;

  coord_t p [3];
  assign p[0] = point_i.point_x;
  assign p[1] = point_i.point_y;
  assign p[2] = point_i.point_z;

  logic              fr_vld, fr_deg;
  logic [LL_W-1:0]   fr_ll;
  logic [QQ_W-1:0]   fr_qq;
  logic [DABS_W-1:0] fr_dabs;

  cscd_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (point_i.valid),
    .p_i     (p),
    .ea_i    (ea_q),
    .eb_i    (eb_q),
    .valid_o (fr_vld),
    .deg_o   (fr_deg),
    .ll_o    (fr_ll),
    .qq_o    (fr_qq),
    .dabs_o  (fr_dabs)
  );

  // axis length
  sq1_pay_t        s1_pin, s1_pout;
  logic            s1_vld;
  logic [L_W-1:0]  s1_len;
  logic [L_W:0]    s1_rem;

  assign s1_pin = '{dabs: fr_dabs, qq: fr_qq, deg: fr_deg};

  cscd_isqrt #(.W(L_W), .PW($bits(sq1_pay_t))) u_sqrt_len (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (fr_vld),
    .rad_i   (fr_ll),
    .pay_i   (s1_pin),
    .valid_o (s1_vld),
    .root_o  (s1_len),
    .rem_o   (s1_rem),
    .pay_o   (s1_pout)
  );

  // divider operands: (|q.d| + L) / 2L
  logic              pr_vld_q;
  logic [DIVN_W-1:0] pr_num_q;
  logic [DIVD_W-1:0] pr_den_q;
  div_pay_t          pr_pay_q;
  logic [L_W:0]      len_inc;

  assign len_inc = {1'b0, s1_len} + 1'b1;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pr_num_q <= DIVN_W'(s1_pout.dabs) + DIVN_W'(s1_len);
      pr_den_q <= {s1_len, 1'b0};
      pr_pay_q <= '{qq: s1_pout.qq, h: len_inc[L_W:1], deg: s1_pout.deg};
    end
  end

  logic              dv_vld;
  logic [PARA_W-1:0] dv_para;
  div_pay_t          dv_pay;

  cscd_div #(.QW(PARA_W), .DW(DIVD_W), .NW(DIVN_W), .PW($bits(div_pay_t))) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (pr_vld_q),
    .num_i   (pr_num_q),
    .den_i   (pr_den_q),
    .pay_i   (pr_pay_q),
    .valid_o (dv_vld),
    .quo_o   (dv_para),
    .pay_o   (dv_pay)
  );

  // axial offset g and radial remainder q.q - 4 para^2
  logic                  p1_vld_q, p2_vld_q;
  logic signed [G_W-1:0] p1_g_q, p2_g_q;
  logic [PSQ_W-1:0]      p1_psq_q;
  logic [QQ_W-1:0]       p1_qq_q;
  logic                  p1_deg_q, p2_deg_q;
  logic [O4_W-1:0]       p2_o4_q;
  logic [P4_W-1:0]       p4, qq_ext, o4_diff;

  assign p4      = {p1_psq_q, 2'b00};
  assign qq_ext  = P4_W'(p1_qq_q);
  assign o4_diff = qq_ext - p4;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_g_q   <= $signed(G_W'(dv_para)) - $signed(G_W'(dv_pay.h));
      p1_psq_q <= PSQ_W'(dv_para) * PSQ_W'(dv_para);
      p1_qq_q  <= dv_pay.qq;
      p1_deg_q <= dv_pay.deg;
      p2_o4_q  <= (qq_ext > p4) ? o4_diff[O4_W-1:0] : '0;
      p2_g_q   <= p1_g_q;
      p2_deg_q <= p1_deg_q;
    end
  end

  sq2_pay_t         s2_pout;
  logic             s2_vld;
  logic [S2R_W-1:0] s2_root;
  logic [S2R_W:0]   s2_rem;

  cscd_isqrt #(.W(S2R_W), .PW($bits(sq2_pay_t))) u_sqrt_rad (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (p2_vld_q),
    .rad_i   (p2_o4_q),
    .pay_i   ({p2_g_q, p2_deg_q}),
    .valid_o (s2_vld),
    .root_o  (s2_root),
    .rem_o   (s2_rem),
    .pay_o   (s2_pout)
  );

  // radial, f, region classification, corner squares
  logic                  fa_vld_q, fb_vld_q, fc_vld_q, fd_vld_q, fe_vld_q;
  logic [S2R_W-1:0]      fa_radial_q;
  logic signed [G_W-1:0] fa_g_q, fb_g_q;
  logic                  fa_deg_q, fb_deg_q, fc_deg_q, fd_deg_q, fe_deg_q;
  logic signed [F_W-1:0] fb_f_q;
  logic [1:0]            fc_region_q, fd_region_q, fe_region_q;
  logic [G_W-1:0]        fc_pre_q, fd_pre_q, fe_pre_q;
  logic [FG_W-1:0]       fc_fm_q, fc_gm_q;
  logic [SQ_W-1:0]       fd_ff_q, fd_gg_q;
  logic [S2_W-1:0]       fe_s2_q;

  logic [S2R_W:0]        root_inc;
  logic                  f_pos, g_pos;
  logic signed [G_W-1:0] f_ext, pre_d;
  logic [1:0]            region_d;

  assign root_inc = {1'b0, s2_root} + 1'b1;
  assign f_ext    = G_W'(fb_f_q);
  assign f_pos    = !fb_f_q[F_W-1] && (fb_f_q != '0);
  assign g_pos    = !fb_g_q[G_W-1] && (fb_g_q != '0);

  always_comb begin
    case ({f_pos, g_pos})
      2'b00:   begin region_d = REG_INSIDE; pre_d = (f_ext > fb_g_q) ? f_ext : fb_g_q; end
      2'b01:   begin region_d = REG_END;    pre_d = fb_g_q; end
      2'b10:   begin region_d = REG_WALL;   pre_d = f_ext; end
      default: begin region_d = REG_CORNER; pre_d = '0; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fa_radial_q <= root_inc[S2R_W:1];
      fa_g_q      <= s2_pout.g;
      fa_deg_q    <= s2_pout.deg;
      fb_f_q      <= $signed(F_W'(fa_radial_q)) - $signed(F_W'(rad_q));
      fb_g_q      <= fa_g_q;
      fb_deg_q    <= fa_deg_q;
      fc_region_q <= region_d;
      fc_pre_q    <= pre_d;
      fc_fm_q     <= fb_f_q[FG_W-1:0];
      fc_gm_q     <= fb_g_q[FG_W-1:0];
      fc_deg_q    <= fb_deg_q;
      fd_ff_q     <= SQ_W'(fc_fm_q) * SQ_W'(fc_fm_q);
      fd_gg_q     <= SQ_W'(fc_gm_q) * SQ_W'(fc_gm_q);
      fd_region_q <= fc_region_q;
      fd_pre_q    <= fc_pre_q;
      fd_deg_q    <= fc_deg_q;
      fe_s2_q     <= S2_W'(fd_ff_q) + S2_W'(fd_gg_q);
      fe_region_q <= fd_region_q;
      fe_pre_q    <= fd_pre_q;
      fe_deg_q    <= fd_deg_q;
    end
  end

  sq3_pay_t         s3_pout;
  logic             s3_vld;
  logic [S3R_W-1:0] s3_root;
  logic [S3R_W:0]   s3_rem;

  cscd_isqrt #(.W(S3R_W), .PW($bits(sq3_pay_t))) u_sqrt_corner (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (fe_vld_q),
    .rad_i   (fe_s2_q),
    .pay_i   ({fe_region_q, fe_pre_q, fe_deg_q}),
    .valid_o (s3_vld),
    .root_o  (s3_root),
    .rem_o   (s3_rem),
    .pay_o   (s3_pout)
  );

  // rounding and selection
  logic                    y1_vld_q;
  logic signed [VAL_W-1:0] y1_val_q;
  logic [1:0]              y1_region_q;
  logic                    y1_deg_q;
  logic [S3R_W:0]          corner_r;
  logic signed [VAL_W-1:0] corner_v, pre_v;

  // round half up: remainder above root means sqrt is past root + 1/2
  assign corner_r = {1'b0, s3_root} + S3R_W'(s3_rem > {1'b0, s3_root});
  assign corner_v = $signed(VAL_W'(corner_r));
  assign pre_v    = VAL_W'($signed(s3_pout.pre));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      y1_val_q    <= (s3_pout.region == REG_CORNER) ? corner_v : pre_v;
      y1_region_q <= s3_pout.region;
      y1_deg_q    <= s3_pout.deg;
    end
  end

  // sign, clip, output register
  logic signed [NEG_W-1:0] v_signed;
  logic                    v_hi, v_lo;
  coord_t                  dist_q;
  logic [1:0]              region_q;
  logic                    deg_q, sat_q;

  assign v_signed = neg_q ? -NEG_W'(y1_val_q) : NEG_W'(y1_val_q);
  assign v_hi     = v_signed > V_HI;
  assign v_lo     = v_signed < V_LO;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (y1_deg_q) begin
        dist_q   <= '0;
        region_q <= REG_INSIDE;
        deg_q    <= 1'b1;
        sat_q    <= 1'b0;
      end else begin
        dist_q   <= v_hi ? V_HI[CW-1:0] : (v_lo ? V_LO[CW-1:0] : v_signed[CW-1:0]);
        region_q <= y1_region_q;
        deg_q    <= 1'b0;
        sat_q    <= v_hi || v_lo;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pr_vld_q  <= 1'b0;
      p1_vld_q  <= 1'b0;
      p2_vld_q  <= 1'b0;
      fa_vld_q  <= 1'b0;
      fb_vld_q  <= 1'b0;
      fc_vld_q  <= 1'b0;
      fd_vld_q  <= 1'b0;
      fe_vld_q  <= 1'b0;
      y1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      pr_vld_q  <= s1_vld;
      p1_vld_q  <= dv_vld;
      p2_vld_q  <= p1_vld_q;
      fa_vld_q  <= s2_vld;
      fb_vld_q  <= fa_vld_q;
      fc_vld_q  <= fb_vld_q;
      fd_vld_q  <= fc_vld_q;
      fe_vld_q  <= fd_vld_q;
      y1_vld_q  <= s3_vld;
      out_vld_q <= y1_vld_q;
    end
  end

  assign result_o.valid      = out_vld_q;
  assign result_o.distance   = dist_q;
  assign result_o.region     = region_q;
  assign result_o.degenerate = deg_q;
  assign result_o.saturated  = sat_q;

endmodule
`default_nettype wire

// ===== rtl/cscd_checker.sv =====
`default_nettype none
module cscd_checker import cscd_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire coord_t     distance_i,
  input wire logic [1:0] region_i,
  input wire logic       degenerate_i,
  input wire logic       saturated_i
);

  localparam coord_t D_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t D_MIN = {1'b1, {(CW-1){1'b0}}};

  // a waiting result item holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(distance_i)
      && $stable(region_i) && $stable(degenerate_i) && $stable(saturated_i))
    else $error("result item changed while stalled");

  // input side only stalls behind a blocked output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without output backpressure");

  a_degenerate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && degenerate_i |-> distance_i == '0 && region_i == REG_INSIDE
      && !saturated_i)
    else $error("degenerate item with nonzero fields");

  a_saturated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && saturated_i |-> distance_i == D_MAX || distance_i == D_MIN)
    else $error("saturated item not at a range limit");

endmodule

bind capped_cylinder_signed_distance_core cscd_checker u_cscd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (point_i.ready),
  .out_valid_i  (result_o.valid),
  .out_ready_i  (result_o.ready),
  .distance_i   (result_o.distance),
  .region_i     (result_o.region),
  .degenerate_i (result_o.degenerate),
  .saturated_i  (result_o.saturated)
);
`default_nettype wire

// ===== test/capped_cylinder_signed_distance_core_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module capped_cylinder_signed_distance_core_tb;
  import cscd_pkg::*;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } point_t;

  typedef struct packed {
    logic signed [CW-1:0] distance;
    logic [1:0]           region;
    logic                 degenerate;
    logic                 saturated;
  } dist_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CW-1:0] cfg_data_i = '0;

  cscd_point_if  pt_if ();
  cscd_result_if res_if ();

  capped_cylinder_signed_distance_core u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .point_i   (pt_if.sink),
    .result_o  (res_if.source)
  );

  always #4 clk_i = ~clk_i;

  localparam int LATENCY = 151;
  localparam longint CYCLE_LIMIT = 400000;

  // shadow registers
  logic signed [CW-1:0] end_a [3];
  logic signed [CW-1:0] end_b [3];
  logic [RW-1:0]        radius_q;
  logic                 negate_q;

  point_t pending_points[$];
  dist_t  expected_dists[$];
  int     src_idle_pct = 0;
  int     snk_idle_pct = 0;
  int     error_count = 0;
  longint cycle_count = 0;
  logic   pt_taken = 1'b0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  function automatic logic [127:0] isqrt(input logic [127:0] n);
    logic [127:0] s;
    logic [127:0] c;
    s = '0;
    for (int i = 63; i >= 0; i--) begin
      c = s | (128'd1 << i);
      if (c * c <= n) s = c;
    end
    return s;
  endfunction

  function automatic dist_t cylinder_distance(input point_t p);
    dist_t r;
    logic signed [127:0] d [3];
    logic signed [127:0] q [3];
    logic signed [127:0] ll, qq, qd, dabs, len, para, h, g, f, o4, val, s2, s;
    logic signed [127:0] pts [3];
    pts[0] = p.x; pts[1] = p.y; pts[2] = p.z;
    r = '0;
    for (int i = 0; i < 3; i++) begin
      d[i] = 128'(end_b[i]) - 128'(end_a[i]);
      q[i] = 2 * pts[i] - 128'(end_a[i]) - 128'(end_b[i]);
    end
    if (d[0] == 0 && d[1] == 0 && d[2] == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    ll = 0; qq = 0; qd = 0;
    for (int i = 0; i < 3; i++) begin
      ll += d[i] * d[i];
      qq += q[i] * q[i];
      qd += q[i] * d[i];
    end
    dabs = qd < 0 ? -qd : qd;
    len = isqrt(ll);
    para = (dabs + len) / (2 * len);
    h = (len + 1) >>> 1;
    g = para - h;
    o4 = qq - 4 * para * para;
    if (o4 < 0) o4 = 0;
    f = ((isqrt(o4) + 1) >>> 1) - 128'(radius_q);
    if (f <= 0 && g <= 0) begin
      r.region = REG_INSIDE; val = f > g ? f : g;
    end else if (f <= 0) begin
      r.region = REG_END; val = g;
    end else if (g <= 0) begin
      r.region = REG_WALL; val = f;
    end else begin
      r.region = REG_CORNER;
      s2 = f * f + g * g;
      s = isqrt(s2);
      if (s2 - s * s > s) s = s + 1;
      val = s;
    end
    if (negate_q) val = -val;
    if (val > 128'sd2147483647) begin
      val = 128'sd2147483647; r.saturated = 1'b1;
    end
    if (val < -128'sd2147483648) begin
      val = -128'sd2147483648; r.saturated = 1'b1;
    end
    r.distance = val[CW-1:0];
    return r;
  endfunction

  // driver; pt_taken holds the handshake seen at the last rising edge
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pt_if.valid <= 1'b0;
    end else if (!pt_if.valid || pt_taken) begin
      if (pending_points.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
        point_t nx;
        nx = pending_points.pop_front();
        pt_if.valid <= 1'b1;
        pt_if.point_x <= nx.x;
        pt_if.point_y <= nx.y;
        pt_if.point_z <= nx.z;
      end else begin
        pt_if.valid <= 1'b0;
      end
    end
  end

  // the ready seen at the rising edge was set at the previous falling edge
  always @(negedge clk_i) begin
    res_if.ready <= rst_ni && ($urandom_range(99) >= snk_idle_pct);
  end

  // monitor
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    pt_taken <= rst_ni && pt_if.valid && pt_if.ready;
    if (rst_ni && pt_if.valid && pt_if.ready)
      expected_dists.push_back(cylinder_distance({pt_if.point_x, pt_if.point_y,
                                                  pt_if.point_z}));
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_dists.size() == 0) begin
        report_mismatch("unexpected item", res_if.distance, 0);
      end else begin
        dist_t w;
        w = expected_dists.pop_front();
        if (res_if.distance !== w.distance) report_mismatch("distance", res_if.distance, w.distance);
        if (res_if.region !== w.region) report_mismatch("region", res_if.region, w.region);
        if (res_if.degenerate !== w.degenerate)
          report_mismatch("degenerate", res_if.degenerate, w.degenerate);
        if (res_if.saturated !== w.saturated)
          report_mismatch("saturated", res_if.saturated, w.saturated);
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    pt_if.valid = 1'b0;
    pt_if.point_x = '0;
    pt_if.point_y = '0;
    pt_if.point_z = '0;
    res_if.ready = 1'b0;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CW-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_END_A_X, CFG_END_A_Y, CFG_END_A_Z: end_a[idx] = data;
      CFG_END_B_X, CFG_END_B_Y, CFG_END_B_Z: end_b[idx - CFG_END_B_X] = data;
      CFG_RADIUS: radius_q = data[RW-1:0];
      default: negate_q = data[0];
    endcase
  endtask

  task automatic drain();
    while (pending_points.size() > 0 || pt_if.valid || expected_dists.size() > 0)
      @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  task automatic set_cylinder(input logic [CW-1:0] ax, ay, az, bx, by, bz,
                              input logic [CW-1:0] rad, input logic neg);
    write_reg(CFG_END_A_X, ax);
    write_reg(CFG_END_A_Y, ay);
    write_reg(CFG_END_A_Z, az);
    write_reg(CFG_END_B_X, bx);
    write_reg(CFG_END_B_Y, by);
    write_reg(CFG_END_B_Z, bz);
    write_reg(CFG_RADIUS, rad);
    write_reg(CFG_NEGATE, {31'd0, neg});
  endtask

  // coordinate scaled to span_bits bits, sometimes full range
  function automatic logic [CW-1:0] rand_coord(input int span_bits);
    logic [CW-1:0] v;
    if ($urandom_range(9) == 0) return $urandom;
    v = $urandom;
    return $signed(v) >>> (CW - span_bits);
  endfunction

  task automatic random_points(input int n);
    int sb;
    for (int i = 0; i < n; i++) begin
      sb = $urandom_range(CW, 12);
      pending_points.push_back({rand_coord(sb), rand_coord(sb), rand_coord(sb)});
    end
  endtask

  initial begin
    logic [CW-1:0] c [6];
    end_a = '{0, 0, 0};
    end_b = '{0, 0, 32'sd1 << 16};
    radius_q = 31'd1 << 16;
    negate_q = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    src_idle_pct = 11;
    snk_idle_pct = 56;

    // reset cylinder: directed points around it
    pending_points.push_back({32'sd0, 32'sd0, 32'sd32768});
    pending_points.push_back({32'sd0, 32'sd0, 32'sd0});
    pending_points.push_back({32'sd0, 32'sd0, 32'sd200000});
    pending_points.push_back({32'sd200000, 32'sd0, 32'sd32768});
    pending_points.push_back({32'sd200000, 32'sd200000, 32'sd200000});
    pending_points.push_back({32'h7fffffff, 32'h7fffffff, 32'h7fffffff});
    pending_points.push_back({32'h80000000, 32'h80000000, 32'h80000000});
    pending_points.push_back({32'hffffffff, 32'h00000001, 32'h80000000});
    drain();

    // extremes: full span axis, zero and max radius, negated
    set_cylinder(32'h80000000, 32'h80000000, 32'h80000000,
                 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b1);
    pending_points.push_back({32'sd0, 32'sd0, 32'sd0});
    pending_points.push_back({32'h7fffffff, 32'h80000000, 32'h0});
    pending_points.push_back({32'h80000000, 32'h7fffffff, 32'h7fffffff});
    pending_points.push_back({32'h7fffffff, 32'h7fffffff, 32'h7fffffff});
    drain();
    set_cylinder(32'h80000000, 0, 0, 32'h7fffffff, 0, 0, 0, 1'b0);
    pending_points.push_back({32'h7fffffff, 32'h80000000, 32'h80000000});
    pending_points.push_back({32'h80000000, 32'h7fffffff, 32'h7fffffff});
    pending_points.push_back({32'sd0, 32'sd5, 32'sd0});
    drain();
    // coinciding ends
    set_cylinder(32'sd12345, -32'sd7, 32'sd99, 32'sd12345, -32'sd7, 32'sd99, 32'sd65536, 1'b1);
    pending_points.push_back({32'sd1, 32'sd2, 32'sd3});
    pending_points.push_back({32'sd12345, -32'sd7, 32'sd99});
    drain();

    // random phases with random cylinders
    for (int ph = 0; ph < 12; ph++) begin
      int sb;
      if (ph == 4) begin
        src_idle_pct = 56; snk_idle_pct = 11;
      end else if (ph == 8) begin
        src_idle_pct = 0; snk_idle_pct = 0;
      end
      sb = $urandom_range(CW, 14);
      for (int k = 0; k < 6; k++) c[k] = rand_coord(sb);
      if (ph == 2) c[3:5] = c[0:2];
      set_cylinder(c[0], c[1], c[2], c[3], c[4], c[5],
                   ph == 5 ? 32'h7fffffff : rand_coord(sb) & 32'h7fffffff,
                   1'($urandom_range(1)));
      random_points(100);
      drain();
    end

    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/cscd_pkg.sv
rtl/cscd_point_if.sv
rtl/cscd_result_if.sv
rtl/cscd_isqrt.sv
rtl/cscd_div.sv
rtl/cscd_front.sv
rtl/capped_cylinder_signed_distance_core.sv
rtl/cscd_checker.sv
test/capped_cylinder_signed_distance_core_tb.sv
